@@ rtl/core/phdr_pkg.sv @@
// phdr_pkg: shared types, constants and helpers of the pes header parser
`timescale 1ns / 1ps
package phdr_pkg;

  localparam int unsigned MAX_STUFFING = 16;

  localparam logic [7:0] PRIV2_ID         = 8'hBF;
  localparam logic [7:0] FILL_BYTE        = 8'hFF;
  localparam logic [7:0] START_CODE_LAST  = 8'h01;
  localparam logic [7:0] STD_MASK         = 8'hC0;
  localparam logic [7:0] STD_MARK         = 8'h40;
  localparam logic [3:0] TS_FORM_PTS      = 4'h2;
  localparam logic [3:0] TS_FORM_PTS_DTS  = 4'h3;
  localparam logic [8:0] POS_MAX          = 9'd511;
  localparam logic [8:0] FIXED_HDR_LEN    = 9'd9;
  localparam logic [2:0] TS_BYTES         = 3'd5;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_BAD_FLAGS  = 3'd2,
    ST_PRIV2_SKIP = 3'd3,
    ST_STUFF_OVF  = 3'd4,
    ST_TRUNCATED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TSK_NONE    = 2'd0,
    TSK_BADCODE = 2'd1,
    TSK_PTS     = 2'd2,
    TSK_PTS_DTS = 2'd3
  } ts_kind_e;

  typedef enum logic [2:0] {
    PH_FIXED = 3'd0,
    PH_STUFF = 3'd1,
    PH_STD   = 3'd2,
    PH_TSCHK = 3'd3,
    PH_PTS   = 3'd4,
    PH_DTS   = 3'd5
  } phase_e;

  // per-packet parse context
  typedef struct packed {
    logic [8:0]  byte_pos;
    phase_e      phase;
    logic        finished;
    logic [7:0]  stream_code;
    logic [15:0] length;
    logic [7:0]  control;
    logic [7:0]  flags;
    logic [7:0]  hdr_len;
    logic [32:0] pts_acc;
    logic [32:0] dts_acc;
    logic [4:0]  stuff_cnt;
    logic        pkt_mode;
    logic [2:0]  ts_index;
    ts_kind_e    ts_kind;
  } parse_state_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  stream_code;
    logic [15:0] pkt_len;
    logic [7:0]  control_byte;
    logic [7:0]  flags_byte;
    logic [7:0]  header_data_length;
    logic [1:0]  timestamp_kind;
    logic [32:0] pts;
    logic [32:0] dts;
    logic [8:0]  payload_offset;
  } result_t;

  // fold one timestamp byte into the 33-bit accumulator
  function automatic logic [32:0] ts_shift(input logic [32:0] acc, input logic [2:0] idx,
                                           input logic [7:0] b);
    logic [32:0] r;
    case (idx)
      3'd0:       r = {30'd0, b[3:1]};
      3'd1, 3'd3: r = {acc[24:0], b};
      default:    r = {acc[25:0], b[7:1]};
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/phdr_if.sv @@
// phdr_if: valid/ready channel interfaces of the pes header parser
`timescale 1ns / 1ps

interface phdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface phdr_cfg_if;
  logic valid;
  logic ready;
  logic syntax_mode;
  modport source (output valid, syntax_mode, input ready);
  modport sink (input valid, syntax_mode, output ready);
endinterface

interface phdr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  stream_code;
  logic [15:0] pkt_len;
  logic [7:0]  control_byte;
  logic [7:0]  flags_byte;
  logic [7:0]  header_data_length;
  logic [1:0]  timestamp_kind;
  logic [32:0] pts;
  logic [32:0] dts;
  logic [8:0]  payload_offset;
  modport source (output valid, status, stream_code, pkt_len, control_byte, flags_byte,
                  header_data_length, timestamp_kind, pts, dts, payload_offset, input ready);
  modport sink (input valid, status, stream_code, pkt_len, control_byte, flags_byte,
                header_data_length, timestamp_kind, pts, dts, payload_offset, output ready);
endinterface

@@ rtl/core/phdr_step.sv @@
// phdr_step: combinational one-byte update of the pes header parse context
`timescale 1ns / 1ps
module phdr_step import phdr_pkg::*; (
  input  parse_state_t st_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_byte_i,
  input  logic         syntax_mode_i,
  output parse_state_t st_o,
  output logic         emit_o,
  output result_t      res_o
);

  logic        mode;
  logic        do_ok;
  logic        do_err;
  logic        do_tsc;
  status_e     err_code;
  logic [2:0]  idx_inc;
  logic        fin_now;
  parse_state_t nxt;

  always_comb begin
    mode     = (st_i.byte_pos == '0) ? syntax_mode_i : st_i.pkt_mode;
    nxt      = st_i;
    nxt.pkt_mode = mode;
    do_ok    = 1'b0;
    do_err   = 1'b0;
    do_tsc   = 1'b0;
    err_code = ST_OK;
    idx_inc  = st_i.ts_index + 3'd1;

    if (!st_i.finished) begin
      case (st_i.phase)
        PH_FIXED: begin
          case (st_i.byte_pos)
            9'd0, 9'd1: begin
              if (data_byte_i != 8'h00) begin
                do_err = 1'b1; err_code = ST_BAD_START;
              end
            end
            9'd2: begin
              if (data_byte_i != START_CODE_LAST) begin
                do_err = 1'b1; err_code = ST_BAD_START;
              end
            end
            9'd3: begin
              nxt.stream_code = data_byte_i;
              if (mode && data_byte_i == PRIV2_ID) begin
                do_err = 1'b1; err_code = ST_PRIV2_SKIP;
              end
            end
            9'd4: nxt.length = {data_byte_i, 8'h00};
            9'd5: begin
              nxt.length[7:0] = data_byte_i;
              if (mode) nxt.phase = PH_STUFF;
            end
            9'd6: nxt.control = data_byte_i;
            9'd7: nxt.flags = data_byte_i;
            default: begin
              nxt.hdr_len = data_byte_i;
              case (st_i.flags[7:6])
                TSK_BADCODE: begin
                  do_err = 1'b1; err_code = ST_BAD_FLAGS;
                end
                TSK_NONE: begin
                  nxt.ts_kind = TSK_NONE;
                  do_ok = 1'b1;
                end
                default: begin
                  nxt.ts_kind  = ts_kind_e'(st_i.flags[7:6]);
                  nxt.ts_index = 3'd0;
                  nxt.phase    = PH_PTS;
                end
              endcase
            end
          endcase
        end
        PH_STUFF: begin
          if (data_byte_i == FILL_BYTE) begin
            if (st_i.stuff_cnt >= 5'(MAX_STUFFING)) begin
              do_err = 1'b1; err_code = ST_STUFF_OVF;
            end else begin
              nxt.stuff_cnt = st_i.stuff_cnt + 5'd1;
            end
          end else if ((data_byte_i & STD_MASK) == STD_MARK) begin
            nxt.phase = PH_STD;
          end else begin
            do_tsc = 1'b1;
          end
        end
        PH_STD:   nxt.phase = PH_TSCHK;
        PH_TSCHK: do_tsc = 1'b1;
        PH_PTS: begin
          nxt.pts_acc  = ts_shift(st_i.pts_acc, st_i.ts_index, data_byte_i);
          nxt.ts_index = idx_inc;
          if (idx_inc >= TS_BYTES) begin
            nxt.ts_index = 3'd0;
            if (st_i.ts_kind == TSK_PTS_DTS) nxt.phase = PH_DTS;
            else do_ok = 1'b1;
          end
        end
        PH_DTS: begin
          nxt.dts_acc  = ts_shift(st_i.dts_acc, st_i.ts_index, data_byte_i);
          nxt.ts_index = idx_inc;
          if (idx_inc >= TS_BYTES) begin
            nxt.ts_index = 3'd0;
            do_ok = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // mpeg-1 timestamp form check
    if (do_tsc) begin
      if (data_byte_i[7:4] == TS_FORM_PTS || data_byte_i[7:4] == TS_FORM_PTS_DTS) begin
        nxt.ts_kind  = (data_byte_i[7:4] == TS_FORM_PTS) ? TSK_PTS : TSK_PTS_DTS;
        nxt.pts_acc  = ts_shift('0, 3'd0, data_byte_i);
        nxt.ts_index = 3'd1;
        nxt.phase    = PH_PTS;
      end else begin
        nxt.ts_kind = TSK_NONE;
        do_ok = 1'b1;
      end
    end

    // result fields from the held header bytes
    res_o.status             = ST_OK;
    res_o.stream_code        = nxt.stream_code;
    res_o.pkt_len            = nxt.length;
    res_o.control_byte       = nxt.control;
    res_o.flags_byte         = nxt.flags;
    res_o.header_data_length = nxt.hdr_len;
    res_o.timestamp_kind     = '0;
    res_o.pts                = '0;
    res_o.dts                = '0;
    res_o.payload_offset     = '0;

    if (do_ok) begin
      res_o.timestamp_kind = nxt.ts_kind;
      res_o.payload_offset = mode ? 9'(st_i.byte_pos + 9'd1)
                                  : FIXED_HDR_LEN + {1'b0, nxt.hdr_len};
      if (nxt.ts_kind == TSK_PTS || nxt.ts_kind == TSK_PTS_DTS) begin
        res_o.pts = nxt.pts_acc;
        if (nxt.ts_kind == TSK_PTS_DTS) res_o.dts = nxt.dts_acc;
        else if (mode) res_o.dts = nxt.pts_acc;
      end
    end else if (do_err) begin
      res_o.status = err_code;
    end

    emit_o  = do_ok || do_err;
    fin_now = st_i.finished || emit_o;
    nxt.finished = fin_now;

    if (last_byte_i) begin
      if (!fin_now) begin
        res_o.status = ST_TRUNCATED;
        emit_o = 1'b1;
      end
      nxt = '0;
    end else if (st_i.byte_pos != POS_MAX) begin
      nxt.byte_pos = st_i.byte_pos + 9'd1;
    end

    st_o = nxt;
  end

endmodule

@@ rtl/core/pes_header_parser_core.sv @@
// pes_header_parser_core: top level of the byte-wise pes header parser
`timescale 1ns / 1ps
// usage
//   in_i   : packet bytes in stream order, last_byte marks the final byte of a packet
//   cfg_i  : syntax_mode, 0 mpeg-2 pes header, 1 mpeg-1 packet header; write it while idle,
//            it takes effect at the first byte of the next packet; cfg_i.ready is always high
//   out_o  : one result per packet, when the header completes or fails, or on the
//            last byte if the packet ends first
// timing
//   one byte per cycle while in_i.ready is high; the parse context updates in the cycle of
//   the input transfer and a result shows on out_o the cycle after the byte that completes it
// stall
//   a single output register holds the result; in_i.ready stays high while that
//   register is empty or being emptied in the same cycle, so bytes keep flowing
//   while the receiver takes a result, and only a held result blocks input
// reset
//   rst_ni clears the parse context to the start of a packet, the result register
//   to empty and syntax_mode to mpeg-2
module pes_header_parser_core import phdr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  phdr_in_if.sink    in_i,
  phdr_cfg_if.sink   cfg_i,
  phdr_out_if.source out_o
);

  parse_state_t st_q, st_d;
  logic         mode_q;
  logic         out_valid_q;
  result_t      res_q, res_d;
  logic         emit;
  logic         in_xfer;

  // byte-wise parse step
  phdr_step u_step (
    .st_i          (st_q),
    .data_byte_i   (in_i.data_byte),
    .last_byte_i   (in_i.last_byte),
    .syntax_mode_i (mode_q),
    .st_o          (st_d),
    .emit_o        (emit),
    .res_o         (res_d)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_xfer     = in_i.valid && in_i.ready;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.syntax_mode;
    end
  end

  // parse context, advanced on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_xfer) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.status             = res_q.status;
  assign out_o.stream_code        = res_q.stream_code;
  assign out_o.pkt_len            = res_q.pkt_len;
  assign out_o.control_byte       = res_q.control_byte;
  assign out_o.flags_byte         = res_q.flags_byte;
  assign out_o.header_data_length = res_q.header_data_length;
  assign out_o.timestamp_kind     = res_q.timestamp_kind;
  assign out_o.pts                = res_q.pts;
  assign out_o.dts                = res_q.dts;
  assign out_o.payload_offset     = res_q.payload_offset;

endmodule

@@ rtl/core/phdr_checker.sv @@
// phdr_checker: port-level assertions for the pes header parser, bound to the top level
`timescale 1ns / 1ps
module phdr_checker import phdr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [1:0]  timestamp_kind_i,
  input logic [32:0] pts_i,
  input logic [8:0]  payload_offset_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a new result only follows an input transfer
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without input transfer");

  // the input side is open whenever the result register is empty
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty result register");

  // error results carry no timestamp or offset
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |->
      timestamp_kind_i == '0 && pts_i == '0 && payload_offset_i == '0)
    else $error("error result with timestamp or offset");

  // status code stays in its defined set
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_TRUNCATED)
    else $error("undefined status code");

endmodule

bind pes_header_parser_core phdr_checker u_phdr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .timestamp_kind_i (out_o.timestamp_kind),
  .pts_i            (out_o.pts),
  .payload_offset_i (out_o.payload_offset)
);
